// ===== sv/gm_pkg.sv =====
// Shared constants, types and the star-closure function of the glob matcher.
package gm_pkg;

    localparam int PATTERN_MAX = 32;
    localparam int POS_W       = PATTERN_MAX + 1;
    localparam int CHAR_W      = 8;
    localparam int PAT_W       = PATTERN_MAX * CHAR_W;
    localparam int LEN_W       = 6;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 64;
    localparam int WORD_W      = 64;
    localparam int QDEPTH      = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    localparam logic [CHAR_W-1:0] STAR_BYTE = 8'h2A;
    localparam logic [CHAR_W-1:0] ONE_BYTE  = 8'h3F;

    localparam logic [CFG_IDX_W-1:0] REG_LENGTH = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WORD_0 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WORD_1 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WORD_2 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WORD_3 = 3'd4;

    localparam logic [POS_W-1:0] START_SET = POS_W'(1);

    // One classified character: which pattern positions accept it.
    typedef struct packed {
        logic [PATTERN_MAX-1:0] hit;
        logic                   last;
        logic                   empty;
    } entry_t;

    // Pattern view used by the position engine.
    typedef struct packed {
        logic [PATTERN_MAX-1:0] star;
        logic [PATTERN_MAX-1:0] in_range;
        logic [LEN_W-1:0]       len;
    } pat_ctl_t;

    // Position i+1 becomes active when i is active and holds a star, in a chain.
    // The chain is the carry chain of star + (star & s).
    function automatic logic [POS_W-1:0] star_close(input logic [POS_W-1:0] s,
                                                    input logic [PATTERN_MAX-1:0] star);
        logic [POS_W:0] a;
        logic [POS_W:0] b;
        logic [POS_W:0] sum;
        logic [POS_W:0] cy;
        a   = {2'b00, star};
        b   = {2'b00, star & s[PATTERN_MAX-1:0]};
        sum = a + b;
        cy  = sum ^ a ^ b;
        return s | cy[POS_W-1:0];
    endfunction

endpackage

// ===== sv/gm_front.sv =====
// Input stage: takes name characters and compares them against every pattern byte.
module gm_front (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [gm_pkg::CHAR_W-1:0]   s_tdata,   // [7:0] character
    input  logic                        s_tlast,
    input  logic                        s_tuser,   // [0] empty_name
    input  logic [gm_pkg::PAT_W-1:0]    pattern,
    output logic                        push,
    output gm_pkg::entry_t              push_entry,
    input  logic                        q_ready
);

    logic           front_valid_reg;
    gm_pkg::entry_t entry_reg;
    gm_pkg::entry_t entry_next;

    always_comb begin
        entry_next.last  = s_tlast;
        entry_next.empty = s_tuser;
        for (int i = 0; i < gm_pkg::PATTERN_MAX; i++) begin
            entry_next.hit[i] = (pattern[i*gm_pkg::CHAR_W +: gm_pkg::CHAR_W] == s_tdata) ||
                                (pattern[i*gm_pkg::CHAR_W +: gm_pkg::CHAR_W] == gm_pkg::ONE_BYTE);
        end
    end

    assign s_tready   = !front_valid_reg || q_ready;
    assign push       = front_valid_reg;
    assign push_entry = entry_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            front_valid_reg <= 1'b0;
        end else if (s_tready) begin
            front_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            entry_reg <= entry_next;
        end
    end

endmodule

// ===== sv/gm_queue.sv =====
// Two-entry queue between the classifier and the position engine.
module gm_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  gm_pkg::entry_t push_entry,
    output logic           in_ready,
    output logic           head_valid,
    output gm_pkg::entry_t head,
    input  logic           pop
);

    gm_pkg::entry_t                entries_reg [gm_pkg::QDEPTH];
    logic [gm_pkg::QPTR_W-1:0]     wr_ptr_reg;
    logic [gm_pkg::QPTR_W-1:0]     rd_ptr_reg;
    logic [gm_pkg::QCNT_W-1:0]     cnt_reg;
    logic                          do_push;
    logic                          do_pop;

    assign in_ready   = cnt_reg != gm_pkg::QCNT_W'(gm_pkg::QDEPTH);
    assign head_valid = cnt_reg != '0;
    assign head       = entries_reg[rd_ptr_reg];
    assign do_push    = push && in_ready;
    assign do_pop     = pop && head_valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                cnt_reg <= cnt_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entries_reg[wr_ptr_reg] <= push_entry;
        end
    end

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= gm_pkg::QCNT_W'(gm_pkg::QDEPTH))
        else $error("queue count above depth");
    a_cnt_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        do_push && do_pop |=> $stable(cnt_reg))
        else $error("queue count moved on simultaneous push and pop");
`endif

endmodule

// ===== sv/gm_back.sv =====
// Position engine: advances the active-position set and produces match results.
module gm_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  gm_pkg::pat_ctl_t  ctl,
    input  logic              head_valid,
    input  gm_pkg::entry_t    head,
    output logic              pop,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic              m_matched
);

    logic [gm_pkg::POS_W-1:0]       state_reg;
    logic [gm_pkg::POS_W-1:0]       res_vec_reg;
    logic                           res_valid_reg;
    logic                           out_valid_reg;
    logic                           matched_reg;

    logic [gm_pkg::POS_W-1:0]       cur;
    logic [gm_pkg::PATTERN_MAX-1:0] adv;
    logic [gm_pkg::POS_W-1:0]       nxt;
    logic [gm_pkg::POS_W-1:0]       res_vec_next;
    logic [gm_pkg::POS_W-1:0]       closed;
    logic                           produces;
    logic                           out_free;
    logic                           res_ready;

    // State is kept before closure so a new pattern applies to reached positions.
    assign cur = gm_pkg::star_close(state_reg, ctl.star);
    assign adv = cur[gm_pkg::PATTERN_MAX-1:0] & ~ctl.star & head.hit & ctl.in_range;
    assign nxt = {1'b0, cur[gm_pkg::PATTERN_MAX-1:0] & ctl.star} | {adv, 1'b0};

    assign produces     = head.last || head.empty;
    assign res_vec_next = head.empty ? gm_pkg::START_SET : nxt;
    assign out_free     = !out_valid_reg || m_tready;
    assign res_ready    = !res_valid_reg || out_free;
    assign pop          = head_valid && (!produces || res_ready);

    assign closed    = gm_pkg::star_close(res_vec_reg, ctl.star);
    assign m_tvalid  = out_valid_reg;
    assign m_matched = matched_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= gm_pkg::START_SET;
            res_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (pop) begin
                state_reg <= produces ? gm_pkg::START_SET : nxt;
            end
            if (res_ready) begin
                res_valid_reg <= pop && produces;
            end
            if (out_free) begin
                out_valid_reg <= res_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop && produces) begin
            res_vec_reg <= res_vec_next;
        end
        if (out_free && res_valid_reg) begin
            matched_reg <= closed[ctl.len];
        end
    end

`ifndef SYNTHESIS
    a_name_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        pop && produces |=> state_reg == gm_pkg::START_SET)
        else $error("active set not restarted after end of name");
    a_res_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid_reg && !out_free |=> res_valid_reg && $stable(res_vec_reg))
        else $error("pending result vector lost while output stalled");
`endif

endmodule

// ===== sv/wildcard_glob_matcher.sv =====
// Top level of the glob matcher: configuration registers and the pipeline.
//
// Usage: write pattern_length (index 0) and pattern_word_0..3 (indexes 1..4)
// through cfg_wr_en/cfg_index/cfg_data while no name is in flight. Then
// stream file-name characters on the s_ channel, one per transaction, with
// s_tlast on the final character; s_tuser marks a name of zero characters
// (its s_tdata and s_tlast are ignored). Each last or empty-name
// transaction yields one m_ transaction whose m_tdata[0] is 1 when the
// whole name matches the whole pattern ('*' any run, '?' one character).
// Throughput is one character per cycle while m_tready does not stall
// the output, set by the active-position update.
// A two-entry queue separates the classifier from the position engine, and
// an output register lets the input keep flowing while a result waits.
// When m_tready is low, results back up through the queue and s_tready
// drops once it is full; nothing is lost. Reset clears the pattern to
// empty, restarts the position set, and drops all queued transactions.
module wildcard_glob_matcher (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [gm_pkg::CHAR_W-1:0]      s_tdata,   // [7:0] character
    input  logic                           s_tlast,
    input  logic                           s_tuser,   // [0] empty_name
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [7:0]                     m_tdata,   // [0] matched, [7:1] zero
    input  logic                           cfg_wr_en,
    input  logic [gm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [gm_pkg::CFG_DATA_W-1:0]  cfg_data
);

    logic [gm_pkg::LEN_W-1:0]       length_reg;
    logic [gm_pkg::PAT_W-1:0]       pattern_reg;
    logic [gm_pkg::LEN_W-1:0]       len_clip;
    gm_pkg::pat_ctl_t               ctl;

    logic                           push;
    gm_pkg::entry_t                 push_entry;
    logic                           q_ready;
    logic                           head_valid;
    gm_pkg::entry_t                 head;
    logic                           pop;
    logic                           matched;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            length_reg  <= '0;
            pattern_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                gm_pkg::REG_LENGTH: length_reg <= cfg_data[gm_pkg::LEN_W-1:0];
                gm_pkg::REG_WORD_0: pattern_reg[0*gm_pkg::WORD_W +: gm_pkg::WORD_W] <= cfg_data;
                gm_pkg::REG_WORD_1: pattern_reg[1*gm_pkg::WORD_W +: gm_pkg::WORD_W] <= cfg_data;
                gm_pkg::REG_WORD_2: pattern_reg[2*gm_pkg::WORD_W +: gm_pkg::WORD_W] <= cfg_data;
                gm_pkg::REG_WORD_3: pattern_reg[3*gm_pkg::WORD_W +: gm_pkg::WORD_W] <= cfg_data;
                default: ;
            endcase
        end
    end

    assign len_clip = (length_reg > gm_pkg::LEN_W'(gm_pkg::PATTERN_MAX)) ?
                      gm_pkg::LEN_W'(gm_pkg::PATTERN_MAX) : length_reg;

    always_comb begin
        ctl.len = len_clip;
        for (int i = 0; i < gm_pkg::PATTERN_MAX; i++) begin
            ctl.in_range[i] = gm_pkg::LEN_W'(i) < len_clip;
            ctl.star[i]     = ctl.in_range[i] &&
                (pattern_reg[i*gm_pkg::CHAR_W +: gm_pkg::CHAR_W] == gm_pkg::STAR_BYTE);
        end
    end

    gm_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .s_tuser    (s_tuser),
        .pattern    (pattern_reg),
        .push       (push),
        .push_entry (push_entry),
        .q_ready    (q_ready)
    );

    gm_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .in_ready   (q_ready),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop)
    );

    gm_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctl        (ctl),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_matched  (matched)
    );

    assign m_tdata = {7'b0, matched};

endmodule
